[sv/ata_task_file_builder_assert.svh]
// Assertion macros shared by the task-file builder modules.
`ifndef ATA_TASK_FILE_BUILDER_ASSERT_SVH
`define ATA_TASK_FILE_BUILDER_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define ATA_TFB_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ata_task_file_builder: same-cycle check failed");

// Check that a condition implies a consequence in the next cycle.
`define ATA_TFB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ata_task_file_builder: next-cycle check failed");

`endif

[sv/ata_tfb_pkg.sv]
// Types, codes and constants of the ATA task-file builder.
package ata_tfb_pkg;

   localparam int ADDR_W    = 48;
   localparam int COUNT_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 48;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Divider geometry: 48-bit dividend, divisor up to 255 * 31.
   localparam int DIV_DIVIDEND_W    = ADDR_W;
   localparam int DIV_DIVISOR_W     = 13;
   localparam int DIV_BITS_PER_STEP = 8;
   localparam int DIV_STEPS_W       = 3;
   localparam logic [DIV_STEPS_W-1:0] DIV_STEPS_CYL =
      DIV_STEPS_W'(DIV_DIVIDEND_W / DIV_BITS_PER_STEP);
   localparam logic [DIV_STEPS_W-1:0] DIV_STEPS_SEC = DIV_STEPS_W'(2);

   // Addressing modes.
   localparam logic [1:0] MODE_CHS   = 2'd0;
   localparam logic [1:0] MODE_LBA28 = 2'd1;
   localparam logic [1:0] MODE_LBA48 = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ADDRESSING_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DMA_ENABLE        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_SELECT_BIT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_SECTORS     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SECTORS_PER_TRACK = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAD_COUNT        = 3'd5;

   // Reset values of the configuration registers.
   localparam logic [7:0] SPT_RESET   = 8'd63;
   localparam logic [4:0] HEADS_RESET = 5'd16;

   // Task-file register indexes.
   localparam logic [2:0] TF_CONTROL = 3'd0;
   localparam logic [2:0] TF_DEVICE  = 3'd1;
   localparam logic [2:0] TF_COUNT   = 3'd2;
   localparam logic [2:0] TF_LBA0    = 3'd3;
   localparam logic [2:0] TF_LBA1    = 3'd4;
   localparam logic [2:0] TF_LBA2    = 3'd5;
   localparam logic [2:0] TF_COMMAND = 3'd6;

   // Register byte values.
   localparam logic [7:0] CTRL_PIO = 8'h02;
   localparam logic [7:0] CTRL_DMA = 8'h00;
   localparam logic [7:0] DEV_BASE = 8'hA0;
   localparam logic [7:0] DEV_LBA  = 8'h40;

   // ATA command codes.
   localparam logic [7:0] CMD_PIO_READ      = 8'h20;
   localparam logic [7:0] CMD_PIO_WRITE     = 8'h30;
   localparam logic [7:0] CMD_PIO_EXT_READ  = 8'h24;
   localparam logic [7:0] CMD_PIO_EXT_WRITE = 8'h34;
   localparam logic [7:0] CMD_DMA_READ      = 8'hC8;
   localparam logic [7:0] CMD_DMA_WRITE     = 8'hCA;
   localparam logic [7:0] CMD_DMA_EXT_READ  = 8'h25;
   localparam logic [7:0] CMD_DMA_EXT_WRITE = 8'h35;

   typedef struct packed {
      logic [1:0]        addressing_mode;
      logic              dma_enable;
      logic              drive_select_bit;
      logic [ADDR_W-1:0] total_sectors;
      logic [7:0]        sectors_per_track;
      logic [4:0]        head_count;
   } cfg_type;

   typedef struct packed {
      logic               is_write;
      logic [ADDR_W-1:0]  block_address;
      logic [COUNT_W-1:0] sector_count;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] reg_index;
      logic [7:0] reg_value;
      logic       status;
      logic       last;
   } rsp_payload_type;

   // One classified request, ready to be sequenced.
   typedef struct packed {
      logic               error;
      logic               lba48;
      logic [7:0]         control;
      logic [7:0]         device;
      logic [COUNT_W-1:0] count;
      logic [ADDR_W-1:0]  addr_bytes;
      logic [7:0]         command;
   } desc_type;

   typedef struct packed {
      logic                      start;
      logic [DIV_DIVIDEND_W-1:0] dividend;
      logic [DIV_DIVISOR_W-1:0]  divisor;
      logic [DIV_STEPS_W-1:0]    steps;
   } div_req_type;

   typedef struct packed {
      logic                      done;
      logic [DIV_DIVIDEND_W-1:0] quotient;
      logic [DIV_DIVISOR_W-1:0]  remainder;
   } div_rsp_type;

   typedef enum logic [2:0] {
      FR_IDLE,
      FR_CYL_START,
      FR_CYL_WAIT,
      FR_SEC_START,
      FR_SEC_WAIT,
      FR_PUSH
   } fr_state_type;

endpackage

[sv/ata_tfb_stream_if.sv]
// Valid/ready stream channel carrying one payload per beat.
interface ata_tfb_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[sv/ata_tfb_queue.sv]
// Short descriptor queue between the front and back halves.
module ata_tfb_queue #(
   parameter int DEPTH = ata_tfb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ata_tfb_pkg::desc_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output ata_tfb_pkg::desc_type head_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   ata_tfb_pkg::desc_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok;
   logic             pop_ok;

   assign full      = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign head_data = slot_ff[rd_ptr_ff];
   assign push_ok   = push && !full;
   assign pop_ok    = pop && not_empty;

   // Advance pointers with wrap and track the fill level.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push_ok, pop_ok})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed descriptor.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[sv/ata_tfb_div.sv]
// Iterative restoring divider, eight quotient bits per cycle.
module ata_tfb_div (
   input  logic                     clock,
   input  logic                     reset,
   input  ata_tfb_pkg::div_req_type div_req,
   output ata_tfb_pkg::div_rsp_type div_rsp
);
   localparam int NW = ata_tfb_pkg::DIV_DIVIDEND_W;
   localparam int DW = ata_tfb_pkg::DIV_DIVISOR_W;
   localparam int SW = ata_tfb_pkg::DIV_STEPS_W;
   localparam int BPS = ata_tfb_pkg::DIV_BITS_PER_STEP;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [SW-1:0] steps_ff, steps_in;
   logic [NW-1:0] work_ff, work_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] divisor_ff, divisor_in;
   logic [NW-1:0] work_v;
   logic [DW-1:0] rem_v;
   logic [DW:0]   trial_v;

   // One step: shift in eight dividend bits, compare and subtract each.
   always_comb begin
      work_v = work_ff;
      rem_v  = rem_ff;
      trial_v = '0;
      for (int j = 0; j < BPS; j++) begin
         trial_v = {rem_v, work_v[NW-1]};
         work_v  = {work_v[NW-2:0], 1'b0};
         if (trial_v >= {1'b0, divisor_ff}) begin
            trial_v   = trial_v - {1'b0, divisor_ff};
            work_v[0] = 1'b1;
         end
         rem_v = trial_v[DW-1:0];
      end
   end

   // Load on start, iterate while busy, flag the final step.
   always_comb begin
      busy_in    = busy_ff;
      steps_in   = steps_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      done_in    = 1'b0;
      if (div_req.start) begin
         busy_in    = 1'b1;
         steps_in   = div_req.steps;
         work_in    = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         work_in  = work_v;
         rem_in   = rem_v;
         steps_in = steps_ff - SW'(1);
         if (steps_ff == SW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         steps_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         steps_ff <= steps_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = work_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

[sv/ata_tfb_front.sv]
// Front half: accept requests, range-check, convert CHS, build descriptors.
`include "ata_task_file_builder_assert.svh"

module ata_tfb_front (
   input  logic                     clock,
   input  logic                     reset,
   input  ata_tfb_pkg::cfg_type     cfg,
   ata_tfb_stream_if.sink           req,
   output logic                     push,
   output ata_tfb_pkg::desc_type    push_data,
   input  logic                     q_full,
   output ata_tfb_pkg::div_req_type div_req,
   input  ata_tfb_pkg::div_rsp_type div_rsp
);
   localparam int AW = ata_tfb_pkg::ADDR_W;
   localparam int CW = ata_tfb_pkg::COUNT_W;
   localparam int DW = ata_tfb_pkg::DIV_DIVISOR_W;

   ata_tfb_pkg::fr_state_type state_ff, state_in;

   logic          wr_ff, wr_in;
   logic [AW-1:0] lba_ff, lba_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] prod_ff, prod_in;
   logic [DW-1:0] trk_rem_ff, trk_rem_in;
   logic [15:0]   cyl_ff, cyl_in;
   logic [3:0]    head_ff, head_in;
   logic [7:0]    sector_ff, sector_in;

   logic          accept;
   logic          is_chs;
   logic          is_l48;
   logic          addr_err;
   logic [7:0]    spt_eff;
   logic [4:0]    hds_eff;
   logic [3:0]    head_direct;
   logic          ready_c;

   // Assemble a descriptor from the fields of one request.
   function automatic ata_tfb_pkg::desc_type make_desc(
      input logic                   err,
      input logic                   wr,
      input logic [CW-1:0]          cnt,
      input logic [AW-1:0]          addr_bytes,
      input logic [3:0]             head,
      input ata_tfb_pkg::cfg_type   c
   );
      ata_tfb_pkg::desc_type d;
      logic chs;
      logic l48;
      chs = (c.addressing_mode == ata_tfb_pkg::MODE_CHS);
      l48 = c.addressing_mode[1];
      d.error      = err;
      d.lba48      = l48;
      d.control    = c.dma_enable ? ata_tfb_pkg::CTRL_DMA : ata_tfb_pkg::CTRL_PIO;
      d.device     = ata_tfb_pkg::DEV_BASE | {3'b000, c.drive_select_bit, 4'b0000}
                     | {4'b0000, head} | (chs ? 8'h00 : ata_tfb_pkg::DEV_LBA);
      d.count      = cnt;
      d.addr_bytes = addr_bytes;
      if (l48) begin
         if (c.dma_enable) begin
            d.command = wr ? ata_tfb_pkg::CMD_DMA_EXT_WRITE : ata_tfb_pkg::CMD_DMA_EXT_READ;
         end else begin
            d.command = wr ? ata_tfb_pkg::CMD_PIO_EXT_WRITE : ata_tfb_pkg::CMD_PIO_EXT_READ;
         end
      end else begin
         if (c.dma_enable) begin
            d.command = wr ? ata_tfb_pkg::CMD_DMA_WRITE : ata_tfb_pkg::CMD_DMA_READ;
         end else begin
            d.command = wr ? ata_tfb_pkg::CMD_PIO_WRITE : ata_tfb_pkg::CMD_PIO_READ;
         end
      end
      return d;
   endfunction

   // Classify the incoming request.
   assign is_chs      = (cfg.addressing_mode == ata_tfb_pkg::MODE_CHS);
   assign is_l48      = cfg.addressing_mode[1];
   assign addr_err    = (req.payload.block_address >= cfg.total_sectors);
   assign spt_eff     = (cfg.sectors_per_track == '0) ? 8'd1 : cfg.sectors_per_track;
   assign hds_eff     = (cfg.head_count == '0) ? 5'd1 : cfg.head_count;
   assign head_direct = is_l48 ? 4'h0 : req.payload.block_address[27:24];
   assign accept      = req.valid && ready_c;
   assign req.ready   = ready_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ata_tfb_pkg::FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state, queue push and divider requests.
   always_comb begin
      state_in   = state_ff;
      ready_c    = 1'b0;
      push       = 1'b0;
      push_data  = make_desc(addr_err, req.payload.is_write, req.payload.sector_count,
                             req.payload.block_address, head_direct, cfg);
      div_req    = '0;
      wr_in      = wr_ff;
      lba_in     = lba_ff;
      cnt_in     = cnt_ff;
      prod_in    = prod_ff;
      trk_rem_in = trk_rem_ff;
      cyl_in     = cyl_ff;
      head_in    = head_ff;
      sector_in  = sector_ff;
      unique case (state_ff)
         ata_tfb_pkg::FR_IDLE: begin
            ready_c = !q_full;
            wr_in   = req.payload.is_write;
            lba_in  = req.payload.block_address;
            cnt_in  = req.payload.sector_count;
            prod_in = {5'b00000, spt_eff} * {8'h00, hds_eff};
            if (accept) begin
               if (addr_err || !is_chs) begin
                  push = 1'b1;
               end else begin
                  state_in = ata_tfb_pkg::FR_CYL_START;
               end
            end
         end
         ata_tfb_pkg::FR_CYL_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = lba_ff;
            div_req.divisor  = prod_ff;
            div_req.steps    = ata_tfb_pkg::DIV_STEPS_CYL;
            state_in         = ata_tfb_pkg::FR_CYL_WAIT;
         end
         ata_tfb_pkg::FR_CYL_WAIT: begin
            if (div_rsp.done) begin
               cyl_in     = div_rsp.quotient[15:0];
               trk_rem_in = div_rsp.remainder;
               state_in   = ata_tfb_pkg::FR_SEC_START;
            end
         end
         ata_tfb_pkg::FR_SEC_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = {3'b000, trk_rem_ff, 32'h0000_0000};
            div_req.divisor  = {5'b00000, spt_eff};
            div_req.steps    = ata_tfb_pkg::DIV_STEPS_SEC;
            state_in         = ata_tfb_pkg::FR_SEC_WAIT;
         end
         ata_tfb_pkg::FR_SEC_WAIT: begin
            if (div_rsp.done) begin
               head_in   = div_rsp.quotient[3:0];
               sector_in = div_rsp.remainder[7:0] + 8'd1;
               state_in  = ata_tfb_pkg::FR_PUSH;
            end
         end
         ata_tfb_pkg::FR_PUSH: begin
            push_data = make_desc(1'b0, wr_ff, cnt_ff,
                                  {24'h000000, cyl_ff, sector_ff}, head_ff, cfg);
            if (!q_full) begin
               push     = 1'b1;
               state_in = ata_tfb_pkg::FR_IDLE;
            end
         end
         default: state_in = ata_tfb_pkg::FR_IDLE;
      endcase
   end

   // Hold request fields and conversion results.
   always_ff @(posedge clock) begin
      wr_ff      <= wr_in;
      lba_ff     <= lba_in;
      cnt_ff     <= cnt_in;
      prod_ff    <= prod_in;
      trk_rem_ff <= trk_rem_in;
      cyl_ff     <= cyl_in;
      head_ff    <= head_in;
      sector_ff  <= sector_in;
   end

   `ATA_TFB_ASSERT_IMPLIES(a_div_done_waited, clock, reset, div_rsp.done,
      state_ff == ata_tfb_pkg::FR_CYL_WAIT || state_ff == ata_tfb_pkg::FR_SEC_WAIT)
   `ATA_TFB_ASSERT_IMPLIES(a_head_fits, clock, reset,
      div_rsp.done && state_ff == ata_tfb_pkg::FR_SEC_WAIT,
      div_rsp.quotient[AW-1:5] == '0)

endmodule

[sv/ata_tfb_back.sv]
// Back half: sequence task-file register writes from queued descriptors.
`include "ata_task_file_builder_assert.svh"

module ata_tfb_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  ata_tfb_pkg::desc_type cur,
   output logic                  pop,
   ata_tfb_stream_if.source      rsp
);
   // Positions in the write sequence.
   localparam logic [3:0] SEQ_CONTROL  = 4'd0;
   localparam logic [3:0] SEQ_DEVICE   = 4'd1;
   localparam logic [3:0] SEQ_COUNT_HI = 4'd2;
   localparam logic [3:0] SEQ_LBA3     = 4'd3;
   localparam logic [3:0] SEQ_LBA4     = 4'd4;
   localparam logic [3:0] SEQ_LBA5     = 4'd5;
   localparam logic [3:0] SEQ_COUNT_LO = 4'd6;
   localparam logic [3:0] SEQ_LBA0     = 4'd7;
   localparam logic [3:0] SEQ_LBA1     = 4'd8;
   localparam logic [3:0] SEQ_LBA2     = 4'd9;

   logic [3:0]                   pos_ff, pos_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   ata_tfb_pkg::rsp_payload_type rsp_ff, rsp_in;
   ata_tfb_pkg::rsp_payload_type beat;
   logic                         load;

   assign load = q_valid && (!rsp_valid_ff || rsp.ready);
   assign pop  = load && beat.last;

   // Pick the register write at the current position.
   always_comb begin
      beat.status = 1'b0;
      beat.last   = 1'b0;
      case (pos_ff)
         SEQ_CONTROL:  begin beat.reg_index = ata_tfb_pkg::TF_CONTROL; beat.reg_value = cur.control; end
         SEQ_DEVICE:   begin beat.reg_index = ata_tfb_pkg::TF_DEVICE;  beat.reg_value = cur.device;  end
         SEQ_COUNT_HI: begin beat.reg_index = ata_tfb_pkg::TF_COUNT;   beat.reg_value = cur.count[15:8]; end
         SEQ_LBA3:     begin beat.reg_index = ata_tfb_pkg::TF_LBA0; beat.reg_value = cur.addr_bytes[31:24]; end
         SEQ_LBA4:     begin beat.reg_index = ata_tfb_pkg::TF_LBA1; beat.reg_value = cur.addr_bytes[39:32]; end
         SEQ_LBA5:     begin beat.reg_index = ata_tfb_pkg::TF_LBA2; beat.reg_value = cur.addr_bytes[47:40]; end
         SEQ_COUNT_LO: begin beat.reg_index = ata_tfb_pkg::TF_COUNT;   beat.reg_value = cur.count[7:0]; end
         SEQ_LBA0:     begin beat.reg_index = ata_tfb_pkg::TF_LBA0; beat.reg_value = cur.addr_bytes[7:0];   end
         SEQ_LBA1:     begin beat.reg_index = ata_tfb_pkg::TF_LBA1; beat.reg_value = cur.addr_bytes[15:8];  end
         SEQ_LBA2:     begin beat.reg_index = ata_tfb_pkg::TF_LBA2; beat.reg_value = cur.addr_bytes[23:16]; end
         default: begin
            beat.reg_index = ata_tfb_pkg::TF_COMMAND;
            beat.reg_value = cur.command;
            beat.last      = 1'b1;
         end
      endcase
      // Out-of-range address: one error beat, nothing written.
      if (cur.error) begin
         beat.reg_index = ata_tfb_pkg::TF_CONTROL;
         beat.reg_value = 8'h00;
         beat.status    = 1'b1;
         beat.last      = 1'b1;
      end
   end

   // Advance the position, skipping the high-order writes outside LBA48.
   always_comb begin
      pos_in       = pos_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (load) begin
         rsp_in       = beat;
         rsp_valid_in = 1'b1;
         if (beat.last) begin
            pos_in = SEQ_CONTROL;
         end else if (pos_ff == SEQ_DEVICE && !cur.lba48) begin
            pos_in = SEQ_COUNT_LO;
         end else begin
            pos_in = pos_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= SEQ_CONTROL;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   `ATA_TFB_ASSERT_IMPLIES(a_error_is_last, clock, reset, rsp_valid_ff && rsp_ff.status,
      rsp_ff.last && rsp_ff.reg_index == ata_tfb_pkg::TF_CONTROL)
   `ATA_TFB_ASSERT_IMPLIES(a_item_held, clock, reset, pos_ff != SEQ_CONTROL, q_valid)
   `ATA_TFB_ASSERT_NEXT(a_mid_item, clock, reset, load && !beat.last, pos_ff != SEQ_CONTROL)

endmodule

[sv/ata_task_file_builder.sv]
// Top level of the ATA task-file builder: configuration registers and wiring.
// Each request on req_chan becomes the ATA task-file register writes that start
// it: seven beats on rsp_chan (control, device, count, LBA0-2, command), eleven
// in LBA48 mode, or a single error beat (status 1) when the address is at or
// beyond total_sectors; the final beat carries last. The back half sends one
// beat per cycle while rsp_chan is ready and a descriptor is queued. In LBA28
// and LBA48 modes the front half takes a request per cycle while its queue has
// room; in CHS mode it takes none until the current one is pushed, and one
// divider (8 quotient bits per cycle) does the cylinder division, then the head
// and sector division, before the push. Configuration is written through
// csr_write_enable, csr_index and csr_write_data; the user must do so only while
// the block is idle, which the block itself does not enforce. Indexes above 5
// are ignored. QUEUE_DEPTH sets the descriptor queue between the halves.
module ata_task_file_builder #(
   parameter int QUEUE_DEPTH = ata_tfb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   ata_tfb_stream_if.sink                     req_chan,
   ata_tfb_stream_if.source                   rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [ata_tfb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ata_tfb_pkg::CSR_DATA_W-1:0] csr_write_data
);
   ata_tfb_pkg::cfg_type     cfg_ff, cfg_in;
   ata_tfb_pkg::desc_type    push_data;
   ata_tfb_pkg::desc_type    head_data;
   ata_tfb_pkg::div_req_type div_req;
   ata_tfb_pkg::div_rsp_type div_rsp;
   logic                     push;
   logic                     pop;
   logic                     q_full;
   logic                     q_valid;

   // Decode configuration writes; drop unknown indexes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            ata_tfb_pkg::CSR_ADDRESSING_MODE:   cfg_in.addressing_mode   = csr_write_data[1:0];
            ata_tfb_pkg::CSR_DMA_ENABLE:        cfg_in.dma_enable        = csr_write_data[0];
            ata_tfb_pkg::CSR_DRIVE_SELECT_BIT:  cfg_in.drive_select_bit  = csr_write_data[0];
            ata_tfb_pkg::CSR_TOTAL_SECTORS:     cfg_in.total_sectors     = csr_write_data[47:0];
            ata_tfb_pkg::CSR_SECTORS_PER_TRACK: cfg_in.sectors_per_track = csr_write_data[7:0];
            ata_tfb_pkg::CSR_HEAD_COUNT:        cfg_in.head_count        = csr_write_data[4:0];
            default:                            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.addressing_mode   <= ata_tfb_pkg::MODE_LBA28;
         cfg_ff.dma_enable        <= 1'b0;
         cfg_ff.drive_select_bit  <= 1'b0;
         cfg_ff.total_sectors     <= '0;
         cfg_ff.sectors_per_track <= ata_tfb_pkg::SPT_RESET;
         cfg_ff.head_count        <= ata_tfb_pkg::HEADS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ata_tfb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req       (req_chan),
      .push      (push),
      .push_data (push_data),
      .q_full    (q_full),
      .div_req   (div_req),
      .div_rsp   (div_rsp)
   );

   ata_tfb_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   ata_tfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_valid),
      .head_data (head_data)
   );

   ata_tfb_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .cur     (head_data),
      .pop     (pop),
      .rsp     (rsp_chan)
   );

endmodule

[tb/sv/ata_task_file_builder_test.sv]
// Self-checking testbench for the ATA task-file builder against a task-file predictor.
module ata_task_file_builder_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [ata_tfb_pkg::ADDR_W-1:0] ADDR_MAX = '1;
   localparam int CYCLE_LIMIT    = 500000;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int SETTLE_CYCLES  = 32;
   localparam int MAX_REPORTS    = 20;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [ata_tfb_pkg::CSR_IDX_W-1:0] csr_index;
   logic [ata_tfb_pkg::CSR_DATA_W-1:0] csr_write_data;

   ata_tfb_stream_if #(.payload_type(ata_tfb_pkg::req_payload_type)) req_chan ();
   ata_tfb_stream_if #(.payload_type(ata_tfb_pkg::rsp_payload_type)) rsp_chan ();

   ata_task_file_builder DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Predictor copy of the disk configuration and the traffic stores
   ata_tfb_pkg::cfg_type disk_cfg;
   ata_tfb_pkg::req_payload_type pending_requests[$];
   ata_tfb_pkg::rsp_payload_type expected_writes[$];

   int error_count       = 0;
   int requests_queued   = 0;
   int requests_accepted = 0;
   int writes_checked    = 0;
   int rejects_seen      = 0;
   int disk_settings     = 0;
   int cycle_count       = 0;
   int holdoff_requests  = 0;
   int holdoff_served    = 0;
   int holdoff_left      = 0;
   int pattern_left      = 0;
   int pattern_mode      = 0;
   int burst_left        = 0;
   int gap_left          = 0;

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_REPORTS)
         $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic logic [ata_tfb_pkg::ADDR_W-1:0] rand48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   function automatic void queue_write(input logic [2:0] idx, input logic [7:0] value,
                                       input logic st, input logic fin);
      ata_tfb_pkg::rsp_payload_type w;
      w.reg_index = idx;
      w.reg_value = value;
      w.status    = st;
      w.last      = fin;
      expected_writes.push_back(w);
   endfunction

   // Expand one request into the task-file writes it should produce
   function automatic void build_task_file(input ata_tfb_pkg::req_payload_type r);
      logic chs, ext, dma;
      logic [7:0] spt;
      logic [4:0] hds;
      logic [ata_tfb_pkg::ADDR_W-1:0] track, cyl, bytes;
      logic [3:0] head;
      logic [7:0] cmd, dev;
      if (r.block_address >= disk_cfg.total_sectors) begin
         queue_write(ata_tfb_pkg::TF_CONTROL, 8'h00, 1'b1, 1'b1);
         return;
      end
      chs   = (disk_cfg.addressing_mode == ata_tfb_pkg::MODE_CHS);
      ext   = (disk_cfg.addressing_mode >= ata_tfb_pkg::MODE_LBA48);
      dma   = disk_cfg.dma_enable;
      bytes = r.block_address;
      head  = 4'h0;
      if (ext) begin
         if (dma) cmd = r.is_write ? ata_tfb_pkg::CMD_DMA_EXT_WRITE
                                   : ata_tfb_pkg::CMD_DMA_EXT_READ;
         else     cmd = r.is_write ? ata_tfb_pkg::CMD_PIO_EXT_WRITE
                                   : ata_tfb_pkg::CMD_PIO_EXT_READ;
      end else begin
         if (dma) cmd = r.is_write ? ata_tfb_pkg::CMD_DMA_WRITE : ata_tfb_pkg::CMD_DMA_READ;
         else     cmd = r.is_write ? ata_tfb_pkg::CMD_PIO_WRITE : ata_tfb_pkg::CMD_PIO_READ;
         if (chs) begin
            // zero geometry counts as one
            spt   = (disk_cfg.sectors_per_track == 8'd0) ? 8'd1 : disk_cfg.sectors_per_track;
            hds   = (disk_cfg.head_count == 5'd0) ? 5'd1 : disk_cfg.head_count;
            track = r.block_address / spt;
            cyl   = track / hds;
            bytes[7:0]  = 8'(r.block_address % spt + 1);
            bytes[23:8] = cyl[15:0];
            head        = 4'(track % hds);
         end else begin
            head = r.block_address[27:24];
         end
      end
      dev = ata_tfb_pkg::DEV_BASE | {3'b000, disk_cfg.drive_select_bit, 4'b0000}
            | {4'b0000, head} | (chs ? 8'h00 : ata_tfb_pkg::DEV_LBA);
      queue_write(ata_tfb_pkg::TF_CONTROL, dma ? ata_tfb_pkg::CTRL_DMA : ata_tfb_pkg::CTRL_PIO,
                  1'b0, 1'b0);
      queue_write(ata_tfb_pkg::TF_DEVICE, dev, 1'b0, 1'b0);
      if (ext) begin
         queue_write(ata_tfb_pkg::TF_COUNT, r.sector_count[15:8], 1'b0, 1'b0);
         queue_write(ata_tfb_pkg::TF_LBA0, bytes[31:24], 1'b0, 1'b0);
         queue_write(ata_tfb_pkg::TF_LBA1, bytes[39:32], 1'b0, 1'b0);
         queue_write(ata_tfb_pkg::TF_LBA2, bytes[47:40], 1'b0, 1'b0);
      end
      queue_write(ata_tfb_pkg::TF_COUNT, r.sector_count[7:0], 1'b0, 1'b0);
      queue_write(ata_tfb_pkg::TF_LBA0, bytes[7:0], 1'b0, 1'b0);
      queue_write(ata_tfb_pkg::TF_LBA1, bytes[15:8], 1'b0, 1'b0);
      queue_write(ata_tfb_pkg::TF_LBA2, bytes[23:16], 1'b0, 1'b0);
      queue_write(ata_tfb_pkg::TF_COMMAND, cmd, 1'b0, 1'b1);
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles, %0d writes still expected", cycle_count,
                  expected_writes.size());
         $display("status: fail");
         $finish;
      end
   end

   // Request driver: bursts of beats with random gaps in between
   always @(posedge clock) begin : sender
      ata_tfb_pkg::req_payload_type next_item;
      logic next_valid;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         next_item  = req_chan.payload;
         next_valid = req_chan.valid;
         if (req_chan.valid && req_chan.ready) begin
            build_task_file(req_chan.payload);
            requests_accepted++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (pending_requests.size() != 0) begin
               next_item  = pending_requests.pop_front();
               next_valid = 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
               end else begin
                  burst_left--;
               end
            end
         end
         req_chan.valid   <= next_valid;
         req_chan.payload <= next_item;
      end
   end

   // Result receiver: hold-offs on request, otherwise a changing stall pattern
   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (holdoff_served != holdoff_requests) begin
         holdoff_served++;
         holdoff_left = HOLDOFF_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else if (holdoff_left != 0) begin
         holdoff_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            pattern_mode = $urandom_range(0, 3);
            pattern_left = $urandom_range(10, 150);
         end else begin
            pattern_left--;
         end
         case (pattern_mode)
            0, 1: rsp_chan.ready <= 1'b1;
            2: rsp_chan.ready <= 1'($urandom_range(0, 1));
            default: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Result monitor: compare each beat with the oldest expected write
   always @(posedge clock) begin : monitor
      ata_tfb_pkg::rsp_payload_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.payload;
         if (expected_writes.size() == 0) begin
            report_mismatch($sformatf("unexpected beat idx=%0d val=%h st=%b last=%b",
                                      got.reg_index, got.reg_value, got.status, got.last));
         end else begin
            want = expected_writes.pop_front();
            writes_checked++;
            if (want.status) rejects_seen++;
            if (got.reg_index !== want.reg_index)
               report_mismatch($sformatf("reg_index %0d, want %0d", got.reg_index,
                                         want.reg_index));
            if (got.reg_value !== want.reg_value)
               report_mismatch($sformatf("reg_value %h, want %h (reg %0d)", got.reg_value,
                                         want.reg_value, want.reg_index));
            if (got.status !== want.status)
               report_mismatch($sformatf("status %b, want %b", got.status, want.status));
            if (got.last !== want.last)
               report_mismatch($sformatf("last %b, want %b", got.last, want.last));
         end
      end
   end

   // Write one configuration register and track it in the predictor
   task automatic write_csr(input logic [ata_tfb_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ata_tfb_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         ata_tfb_pkg::CSR_ADDRESSING_MODE:   disk_cfg.addressing_mode   = data[1:0];
         ata_tfb_pkg::CSR_DMA_ENABLE:        disk_cfg.dma_enable        = data[0];
         ata_tfb_pkg::CSR_DRIVE_SELECT_BIT:  disk_cfg.drive_select_bit  = data[0];
         ata_tfb_pkg::CSR_TOTAL_SECTORS:     disk_cfg.total_sectors     = data;
         ata_tfb_pkg::CSR_SECTORS_PER_TRACK: disk_cfg.sectors_per_track = data[7:0];
         ata_tfb_pkg::CSR_HEAD_COUNT:        disk_cfg.head_count        = data[4:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Program every register, sometimes with junk above the field width
   task automatic set_disk(input logic [1:0] mode, input logic dma, input logic drive,
                           input logic [ata_tfb_pkg::ADDR_W-1:0] total, input logic [7:0] spt,
                           input logic [4:0] heads);
      logic [ata_tfb_pkg::CSR_DATA_W-1:0] junk;
      junk = rand48() & {ata_tfb_pkg::CSR_DATA_W{1'($urandom_range(0, 1))}};
      write_csr(ata_tfb_pkg::CSR_ADDRESSING_MODE, {junk[47:2], mode});
      write_csr(ata_tfb_pkg::CSR_DMA_ENABLE, {junk[47:1], dma});
      write_csr(ata_tfb_pkg::CSR_DRIVE_SELECT_BIT, {junk[47:1], drive});
      write_csr(ata_tfb_pkg::CSR_TOTAL_SECTORS, total);
      write_csr(ata_tfb_pkg::CSR_SECTORS_PER_TRACK, {junk[47:8], spt});
      write_csr(ata_tfb_pkg::CSR_HEAD_COUNT, {junk[47:5], heads});
      disk_settings++;
   endtask

   task automatic add_request(input logic wr, input logic [ata_tfb_pkg::ADDR_W-1:0] lba,
                              input logic [ata_tfb_pkg::COUNT_W-1:0] cnt);
      ata_tfb_pkg::req_payload_type r;
      r.is_write      = wr;
      r.block_address = lba;
      r.sector_count  = cnt;
      pending_requests.push_back(r);
      requests_queued++;
   endtask

   // Wait until every request is taken, every write is back and the block settles
   task automatic drain_block();
      do @(posedge clock);
      while (requests_accepted != requests_queued || expected_writes.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly in-range addresses of varied magnitude, some at or past the end
   function automatic logic [ata_tfb_pkg::ADDR_W-1:0] pick_address(
      input logic [ata_tfb_pkg::ADDR_W-1:0] limit);
      logic [ata_tfb_pkg::ADDR_W-1:0] r;
      logic [ata_tfb_pkg::ADDR_W:0] span;
      r    = rand48() >> (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 47));
      span = {1'b0, ADDR_MAX} - {1'b0, limit} + 1;
      case ($urandom_range(0, 9))
         0: return limit;
         1: return limit + 48'({1'b0, r} % span);
         2: return (limit != 0) ? limit - 1 : r;
         default: return (limit != 0) ? r % limit : r;
      endcase
   endfunction

   task automatic run_random_phase(input int n, input logic hold_off);
      logic [1:0] mode;
      logic [ata_tfb_pkg::ADDR_W-1:0] total;
      logic [7:0] spt;
      logic [4:0] heads;
      logic [ata_tfb_pkg::COUNT_W-1:0] cnt;
      mode = hold_off ? ata_tfb_pkg::MODE_LBA48 : 2'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
         0: total = ADDR_MAX;
         1: total = rand48();
         2: total = 48'($urandom_range(1, 5000));
         default: total = rand48() >> $urandom_range(0, 40);
      endcase
      case ($urandom_range(0, 4))
         0: spt = 8'd0;
         1: spt = 8'd1;
         2: spt = 8'd255;
         default: spt = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 4))
         0: heads = 5'd0;
         1: heads = 5'd1;
         2: heads = 5'd16;
         3: heads = 5'd31;
         default: heads = 5'($urandom_range(0, 31));
      endcase
      set_disk(mode, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), total, spt, heads);
      // stall the receiver while the sender keeps offering
      if (hold_off) holdoff_requests++;
      repeat (n) begin
         case ($urandom_range(0, 9))
            0: cnt = '0;
            1: cnt = '1;
            default: cnt = 16'($urandom);
         endcase
         add_request(1'($urandom_range(0, 1)), pick_address(total), cnt);
      end
      drain_block();
   endtask

   // Stimulus
   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      disk_cfg.addressing_mode   = ata_tfb_pkg::MODE_LBA28;
      disk_cfg.dma_enable        = 1'b0;
      disk_cfg.drive_select_bit  = 1'b0;
      disk_cfg.total_sectors     = '0;
      disk_cfg.sectors_per_track = ata_tfb_pkg::SPT_RESET;
      disk_cfg.head_count        = ata_tfb_pkg::HEADS_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: empty drive rejects everything
      add_request(1'b0, '0, 16'h0001);
      add_request(1'b1, ADDR_MAX, 16'hFFFF);
      drain_block();

      // lba48 pio across the full address range, end of drive rejected
      set_disk(ata_tfb_pkg::MODE_LBA48, 1'b0, 1'b1, ADDR_MAX, 8'd63, 5'd16);
      add_request(1'b1, ADDR_MAX - 1, 16'hFFFF);
      add_request(1'b0, '0, 16'h0000);
      add_request(1'b0, ADDR_MAX, 16'h0001);
      add_request(1'b1, 48'hAAAA_5555_AAAA, 16'h5AA5);
      drain_block();

      // unused mode code behaves as lba48, dma commands
      set_disk(2'd3, 1'b1, 1'b0, ADDR_MAX, 8'd63, 5'd16);
      add_request(1'b0, 48'h1234_5678_9ABC, 16'h0100);
      add_request(1'b1, 48'h5555_AAAA_5555, 16'hA55A);
      drain_block();

      // lba28 drops address bits above 27
      set_disk(ata_tfb_pkg::MODE_LBA28, 1'b1, 1'b1, ADDR_MAX, 8'd63, 5'd16);
      add_request(1'b0, 48'hFFFF_F123_4567, 16'h01FF);
      add_request(1'b1, 48'h0000_0FFF_FFFF, 16'h0000);
      drain_block();

      // chs with widest tracks, cylinder wraps at the top of the range
      set_disk(ata_tfb_pkg::MODE_CHS, 1'b0, 1'b0, ADDR_MAX, 8'd255, 5'd16);
      add_request(1'b0, '0, 16'h0001);
      add_request(1'b1, ADDR_MAX - 1, 16'h0080);
      add_request(1'b0, 48'd16064, 16'h0002);
      drain_block();

      // chs with zero geometry
      set_disk(ata_tfb_pkg::MODE_CHS, 1'b0, 1'b1, ADDR_MAX, 8'd0, 5'd0);
      add_request(1'b1, 48'd1000, 16'h0008);
      add_request(1'b0, 48'd7, 16'h0001);
      drain_block();

      // chs with more than sixteen heads, drive size boundary
      set_disk(ata_tfb_pkg::MODE_CHS, 1'b1, 1'b0, 48'd100000, 8'd1, 5'd31);
      add_request(1'b0, 48'd99999, 16'h0003);
      add_request(1'b1, 48'd100000, 16'h0003);
      add_request(1'b1, 48'd30, 16'h0005);
      drain_block();

      // writes to unused register indexes change nothing
      write_csr(3'd6, rand48());
      write_csr(3'd7, rand48());
      add_request(1'b0, 48'd5, 16'h0009);
      drain_block();

      // random settings and traffic, one phase under a long receiver stall
      run_random_phase(25, 1'b0);
      run_random_phase(25, 1'b1);
      repeat (4) run_random_phase(25, 1'b0);

      $display("covered %0d requests (%0d rejected), %0d task-file writes checked",
               requests_accepted, rejects_seen, writes_checked);
      $display("over %0d disk settings, %0d mismatches", disk_settings, error_count);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/ata_tfb_pkg.sv
sv/ata_tfb_stream_if.sv
sv/ata_tfb_queue.sv
sv/ata_tfb_div.sv
sv/ata_tfb_front.sv
sv/ata_tfb_back.sv
sv/ata_task_file_builder.sv
tb/sv/ata_task_file_builder_test.sv
